// ===== rtl/aopb_pkg.sv =====
// ----------------------------------------------------------------------------
// aopb_pkg: shared types and constants of the ARGB-over-pixel blend.
// Holds the configuration codes, the packed 565 mask and the records that
// travel between the three pipeline stages.
// ----------------------------------------------------------------------------
package aopb_pkg;

    // Register indexes of the configuration port.
    localparam int unsigned CfgIndexWidth = 8;
    localparam logic [CfgIndexWidth-1:0] CFG_BACK_FORMAT = 8'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_BLEND_MODE  = 8'd1;

    // Background format codes.
    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_ARGB8888 = 1'b1;

    // Blend mode codes.
    localparam logic MODE_BLEND   = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    // Green in the upper half, red and blue in the lower half.
    localparam logic [31:0] PACK_MASK = 32'h07E0_F81F;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic back_format;
        logic blend_mode;
    } t_cfg;

    // Record after the first stage: operands ready for the multipliers.
    typedef struct packed {
        logic             fmt_8888;
        logic             skip;
        logic             copy_fore;
        logic [31:0]      fore;
        logic [15:0]      back16;
        logic [31:0]      pb;
        logic [31:0]      diff565;
        logic [5:0]       a5;
        logic [7:0]       back_alpha;
        logic [7:0]       alpha;
        logic [2:0][7:0]  bc;
        logic [2:0][8:0]  cdiff;
    } t_prep;

    // Record after the second stage: products ready for the final add.
    typedef struct packed {
        logic             fmt_8888;
        logic             skip;
        logic             copy_fore;
        logic [31:0]      fore;
        logic [15:0]      back16;
        logic [31:0]      pb;
        logic [31:0]      prod565;
        logic [7:0]       back_alpha;
        logic [2:0][7:0]  bc;
        logic [2:0][7:0]  cstep;
    } t_mult;

    // Final result record.
    typedef struct packed {
        logic [31:0] pixel;
        logic        write_enable;
    } t_result;

endpackage

// ===== rtl/argb_over_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// argb_over_pixel_blend: alpha blend of an ARGB8888 pixel over a background.
// Three-stage pipeline: operand preparation, multiply, final add and select.
// ----------------------------------------------------------------------------
// The block accepts one foreground/background pixel pair per clock while
// o_stall is low and delivers the blended pixel from the merge stage's output
// register, in the background format selected by back_format (RGB565 in
// the low half, or ARGB8888), together with a write flag. There are three
// register stages, the multipliers sitting alone in the middle one; each
// stage holds its item under output stall and still fills while it is empty,
// so a stalled result does not stop items behind it from closing up.
// Configuration is written through the plain write port; the user must
// write it only while no item is in flight; the block does not enforce this.
module argb_over_pixel_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic [aopb_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_fore_pixel,
    input  logic [31:0] i_back_pixel,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_pixel,
    output logic        o_write_enable
);
    import aopb_pkg::*;

    t_cfg    r_cfg;
    logic    prep_ready;
    logic    prep_valid;
    t_prep   prep_data;
    logic    mult_ready;
    logic    mult_valid;
    t_mult   mult_data;
    logic    merge_ready;
    t_result result;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.back_format <= FMT_RGB565;
            r_cfg.blend_mode  <= MODE_BLEND;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BACK_FORMAT: r_cfg.back_format <= i_cfg_data[0];
                CFG_BLEND_MODE:  r_cfg.blend_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage one: operand preparation.
    aopb_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (prep_ready),
        .i_fore_pixel (i_fore_pixel),
        .i_back_pixel (i_back_pixel),
        .o_valid      (prep_valid),
        .i_ready      (mult_ready),
        .o_data       (prep_data)
    );

    // Stage two: multipliers.
    aopb_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .o_ready (mult_ready),
        .i_data  (prep_data),
        .o_valid (mult_valid),
        .i_ready (merge_ready),
        .o_data  (mult_data)
    );

    // Stage three: final add, selection and output register.
    aopb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mult_valid),
        .o_ready (merge_ready),
        .i_data  (mult_data),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_data  (result)
    );

    assign o_stall        = !prep_ready;
    assign o_result_pixel = result.pixel;
    assign o_write_enable = result.write_enable;

endmodule

// ===== rtl/aopb_prep.sv =====
// ----------------------------------------------------------------------------
// aopb_prep: first pipeline stage.
// Reduces the foreground to RGB565, packs both 565 colors, forms the
// differences and the alpha values, and decides the special cases.
// ----------------------------------------------------------------------------
module aopb_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aopb_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_fore_pixel,
    input  logic [31:0]          i_back_pixel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output aopb_pkg::t_prep      o_data
);
    import aopb_pkg::*;

    logic        r_valid;
    t_prep       r_data;
    t_prep       n_data;
    logic [15:0] fore16;
    logic [8:0]  alpha_inc;

    // Operand preparation.
    always_comb begin
        fore16    = {i_fore_pixel[23:19], i_fore_pixel[15:10], i_fore_pixel[7:3]};
        alpha_inc = {1'b0, i_fore_pixel[31:24]} + 9'd1;

        n_data.fmt_8888   = (i_cfg.back_format == FMT_ARGB8888);
        n_data.skip       = (i_cfg.back_format == FMT_RGB565)
                            && (i_cfg.blend_mode == MODE_CONVERT)
                            && (i_fore_pixel[31:24] == 8'd0);
        n_data.copy_fore  = (i_cfg.blend_mode == MODE_CONVERT)
                            || (i_back_pixel[31:24] == 8'd0);
        n_data.fore       = i_fore_pixel;
        n_data.back16     = i_back_pixel[15:0];
        n_data.pb         = {i_back_pixel[15:0], i_back_pixel[15:0]} & PACK_MASK;
        n_data.diff565    = ({fore16, fore16} & PACK_MASK) - n_data.pb;
        n_data.a5         = alpha_inc[8:3];
        n_data.back_alpha = i_back_pixel[31:24];
        n_data.alpha      = i_fore_pixel[31:24];
        for (int k = 0; k < 3; k++) begin
            n_data.bc[k]    = i_back_pixel[8*k +: 8];
            n_data.cdiff[k] = {1'b0, i_fore_pixel[8*k +: 8]}
                              - {1'b0, i_back_pixel[8*k +: 8]};
        end
    end

    // The stage takes a new item when it is empty or its item moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/aopb_mult.sv =====
// ----------------------------------------------------------------------------
// aopb_mult: second pipeline stage.
// Scales the packed 565 difference by the 6-bit alpha and each 8888 channel
// difference by the 8-bit alpha.
// ----------------------------------------------------------------------------
module aopb_mult (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  aopb_pkg::t_prep      i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output aopb_pkg::t_mult      o_data
);
    import aopb_pkg::*;

    logic              r_valid;
    t_mult             r_data;
    t_mult             n_data;
    logic [31:0]       wide565;
    logic signed [17:0] cprod [3];

    // Products. The 565 product wraps at 32 bits; a channel product keeps only
    // its bits 15..8, a shift right by 8, and only these reach the result.
    always_comb begin
        wide565 = i_data.diff565 * {26'd0, i_data.a5};

        n_data.fmt_8888   = i_data.fmt_8888;
        n_data.skip       = i_data.skip;
        n_data.copy_fore  = i_data.copy_fore;
        n_data.fore       = i_data.fore;
        n_data.back16     = i_data.back16;
        n_data.pb         = i_data.pb;
        n_data.prod565    = wide565;
        n_data.back_alpha = i_data.back_alpha;
        n_data.bc         = i_data.bc;
        for (int k = 0; k < 3; k++) begin
            cprod[k]        = $signed({{9{i_data.cdiff[k][8]}}, i_data.cdiff[k]})
                              * $signed({10'd0, i_data.alpha});
            n_data.cstep[k] = cprod[k][15:8];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/aopb_merge.sv =====
// ----------------------------------------------------------------------------
// aopb_merge: third pipeline stage and output register.
// Adds the scaled differences back onto the background, folds the packed
// 565 word and selects the result for the active format and mode.
// ----------------------------------------------------------------------------
module aopb_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  aopb_pkg::t_mult      i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output aopb_pkg::t_result    o_data
);
    import aopb_pkg::*;

    logic        r_valid;
    t_result     r_data;
    t_result     n_data;
    logic [31:0] mixed;
    logic [15:0] folded;
    logic [2:0][7:0] chan;

    // Final add and result selection.
    always_comb begin
        mixed  = ((i_data.prod565 >> 5) + i_data.pb) & PACK_MASK;
        folded = mixed[15:0] | mixed[31:16];
        for (int k = 0; k < 3; k++) begin
            chan[k] = i_data.bc[k] + i_data.cstep[k];
        end

        n_data.write_enable = 1'b1;
        if (!i_data.fmt_8888) begin
            if (i_data.skip) begin
                n_data.pixel        = {16'd0, i_data.back16};
                n_data.write_enable = 1'b0;
            end else begin
                n_data.pixel = {16'd0, folded};
            end
        end else if (i_data.copy_fore) begin
            n_data.pixel = i_data.fore;
        end else begin
            n_data.pixel = {i_data.back_alpha, chan[2], chan[1], chan[0]};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
